/* sv/assert_macros.svh */
// assertion macros used by first_fit_hole_allocator
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("check failed");

// antecedent implies consequent at the same edge
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// antecedent implies consequent at the next edge
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* sv/ffha_pkg.sv */
// package for the first-fit hole allocator: sizes, codes and types
// no dependencies
`default_nettype none
package ffha_pkg;
  localparam int unsigned NumHoles    = 128;
  localparam int unsigned AlignBytes  = 8;
  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned DataOffset  = 8;

  localparam int unsigned IdxW = $clog2(NumHoles);
  localparam int unsigned CntW = $clog2(NumHoles + 1);
  localparam int unsigned AlignW = $clog2(AlignBytes);

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_RELEASE = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_LEAKED  = 2'd2;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } hole_t;
endpackage
`default_nettype wire

/* sv/ffha_ram.sv */
// hole table memory: one write port, one registered read port
// uses ffha_pkg
`default_nettype none
module ffha_ram
  import ffha_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IdxW-1:0] waddr,
  input  wire hole_t           wdata,
  input  wire logic [IdxW-1:0] raddr,
  output hole_t                rdata
);
  hole_t mem [NumHoles];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/first_fit_hole_allocator.sv */
// first-fit hole allocator top level: sequencer, shared compare unit and table
// uses ffha_pkg, ffha_ram and assert_macros.svh
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | opcode, request_size, region_start
//  out     | out_valid | out_stall | status, data_address, granted_bytes
//
// a request walks the table one entry at a time (read, then compare), and
// removal or insertion adds a shift pass (read, then write, per moved entry).
// the table memory has one read and one write port; that sets the pace.
// reset empties the table at once (fill count only, no clearing pass).
// a finished result waits in the output register; in_stall stays high
// until that result is taken and the sequencer is back in idle.
`default_nettype none
module first_fit_hole_allocator
  import ffha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [31:0] request_size,
  input  wire logic [31:0] region_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      data_address,
  output logic [31:0]      granted_bytes
);
`include "assert_macros.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_NXTRD = 4'd3;  // release: read entry after merged one
  localparam logic [3:0] S_NXTCK = 4'd4;
  localparam logic [3:0] S_RMRD  = 4'd5;  // remove: read j+1
  localparam logic [3:0] S_RMWR  = 4'd6;
  localparam logic [3:0] S_INRD  = 4'd7;  // insert: read j-1
  localparam logic [3:0] S_INWR  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]      state;
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;      // scan / shift pointer
  logic [CntW-1:0] pos;      // entry found for merge or insert
  logic            op;
  logic [31:0]     size;
  logic [31:0]     addr;
  logic [32:0]     grant;    // rounded size for allocate
  hole_t           cur;      // merged hole held while checking the next one

  logic            we;
  logic [IdxW-1:0] waddr;
  hole_t           wdata;
  logic [IdxW-1:0] raddr;
  hole_t           rdata;

  ffha_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared 33-bit compare unit terms
  logic [32:0] r_end;
  logic [32:0] top;
  assign r_end = {1'b0, rdata.start} + {1'b0, rdata.length};
  assign top   = {1'b0, addr} + {1'b0, size};

  logic [32:0] round_in;
  assign round_in = {1'b0, request_size} + 33'(AlignBytes + HeaderBytes);

  assign in_stall = (state != S_IDLE) || out_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      we        <= 1'b0;
    end else begin
      we <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op    <= opcode;
            size  <= request_size;
            addr  <= region_start;
            grant <= {round_in[32:AlignW], AlignW'(0)};
            idx   <= '0;
            raddr <= '0;
            status        <= ST_OK;
            data_address  <= '0;
            granted_bytes <= '0;
            if (opcode == OP_ALLOC) begin
              if (round_in[32]) begin
                status <= ST_NOFIT;
                state  <= S_DONE;
              end else begin
                state <= S_RD;
              end
            end else if (request_size == 32'd0) begin
              state <= S_DONE;
            end else if (33'({1'b0, region_start}) + 33'(request_size) > 33'h0FFFFFFFF) begin
              status <= ST_LEAKED;
              state  <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          // read issued last cycle at idx
          if (idx >= count) begin
            if (op == OP_ALLOC) begin
              status <= ST_NOFIT;
              state  <= S_DONE;
            end else if (count >= CntW'(NumHoles)) begin
              status <= ST_LEAKED;
              state  <= S_DONE;
            end else begin
              pos   <= idx;
              idx   <= count;
              raddr <= IdxW'(count - 1'b1);
              state <= S_INRD;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (op == OP_ALLOC) begin
            if ({1'b0, rdata.length} >= grant) begin
              data_address  <= rdata.start + 32'(DataOffset);
              granted_bytes <= grant[31:0];
              if (rdata.length == grant[31:0]) begin
                pos   <= idx;
                raddr <= IdxW'(idx + 1'b1);
                state <= S_RMRD;
              end else begin
                we    <= 1'b1;
                waddr <= idx[IdxW-1:0];
                wdata <= '{start: rdata.start + grant[31:0],
                           length: rdata.length - grant[31:0]};
                state <= S_DONE;
              end
            end else begin
              idx   <= idx + 1'b1;
              raddr <= IdxW'(idx + 1'b1);
              state <= S_RD;
            end
          end else begin
            if (r_end == {1'b0, addr}) begin
              // merge at the low side, then check the following hole
              cur   <= '{start: rdata.start, length: top[31:0] - rdata.start};
              pos   <= idx;
              raddr <= IdxW'(idx + 1'b1);
              state <= S_NXTRD;
            end else if (rdata.start > addr) begin
              if (top == {1'b0, rdata.start}) begin
                we    <= 1'b1;
                waddr <= idx[IdxW-1:0];
                wdata <= '{start: addr, length: rdata.length + size};
                state <= S_DONE;
              end else if (count >= CntW'(NumHoles)) begin
                status <= ST_LEAKED;
                state  <= S_DONE;
              end else begin
                pos   <= idx;
                idx   <= count;
                raddr <= IdxW'(count - 1'b1);
                state <= S_INRD;
              end
            end else begin
              idx   <= idx + 1'b1;
              raddr <= IdxW'(idx + 1'b1);
              state <= S_RD;
            end
          end
        end
        S_NXTRD: begin
          state <= S_NXTCK;
        end
        S_NXTCK: begin
          we    <= 1'b1;
          waddr <= pos[IdxW-1:0];
          if ((pos + 1'b1 < count) && (top == {1'b0, rdata.start})) begin
            wdata <= '{start: cur.start, length: r_end[31:0] - cur.start};
            pos   <= pos + 1'b1;
            raddr <= IdxW'(pos + 2'd2);
            state <= S_RMRD;
          end else begin
            wdata <= cur;
            state <= S_DONE;
          end
        end
        S_RMRD: begin
          // pos is the entry being removed; raddr points at pos+1
          if (pos + 1'b1 >= count) begin
            count <= count - 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_RMWR;
          end
        end
        S_RMWR: begin
          we    <= 1'b1;
          waddr <= pos[IdxW-1:0];
          wdata <= rdata;
          pos   <= pos + 1'b1;
          raddr <= IdxW'(pos + 2'd2);
          state <= S_RMRD;
        end
        S_INRD: begin
          // idx is the slot being filled, moving down toward pos; raddr is idx-1
          if (idx == pos) begin
            we    <= 1'b1;
            waddr <= pos[IdxW-1:0];
            wdata <= '{start: addr, length: size};
            count <= count + 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_INWR;
          end
        end
        S_INWR: begin
          // move the entry below up by one and read the next one down
          we    <= 1'b1;
          waddr <= idx[IdxW-1:0];
          wdata <= rdata;
          idx   <= idx - 1'b1;
          raddr <= IdxW'(idx - 2'd2);
          state <= S_INRD;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPLY(a_count_range, clk, rst, 1'b1, count <= CntW'(NumHoles))
  `CHK_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, state != S_IDLE)
  `CHK_IMPLY(a_out_idle, clk, rst, out_valid && out_stall, in_stall)
  `CHK_IMPLY(a_nofit_zero, clk, rst, out_valid && status != ST_OK,
             data_address == 32'd0 && granted_bytes == 32'd0)
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// testbench for the first-fit hole allocator: random and directed requests
// checked against a behavioural hole table; depends on ffha_pkg and the rtl
`default_nettype none
module tb;
  import ffha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 200000;

  typedef struct {
    logic        op;
    logic [31:0] size;
    logic [31:0] addr;
  } req_t;

  typedef struct {
    logic [1:0]  st;
    logic [31:0] daddr;
    logic [31:0] gbytes;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = 1'b0;
  logic [31:0] request_size = '0;
  logic [31:0] region_start = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] data_address;
  logic [31:0] granted_bytes;

  first_fit_hole_allocator u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .request_size(request_size), .region_start(region_start),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .data_address(data_address), .granted_bytes(granted_bytes)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioural hole table
  logic [31:0] tbl_start [NumHoles];
  logic [31:0] tbl_len   [NumHoles];
  int unsigned tbl_used = 0;

  req_t   pending_reqs[$];
  grant_t expected_grants[$];
  int     errors = 0;
  int     n_alloc_ok = 0, n_nofit = 0, n_leaked = 0, n_release_ok = 0;
  bit     stim_done = 1'b0;
  bit     drain_hold = 1'b0;

  function automatic void drop_hole(int unsigned k);
    for (int unsigned j = k; j + 1 < tbl_used; j++) begin
      tbl_start[j] = tbl_start[j+1];
      tbl_len[j]   = tbl_len[j+1];
    end
    tbl_used--;
  endfunction

  function automatic grant_t predict_grant(req_t r);
    grant_t g;
    logic [33:0] need, top, e;
    int unsigned i;
    g = '{ST_OK, 32'd0, 32'd0};
    if (r.op == OP_ALLOC) begin
      need = ({2'b0, r.size} + AlignBytes + HeaderBytes) & ~34'(AlignBytes - 1);
      g.st = ST_NOFIT;
      if (need > 34'hFFFF_FFFF) return g;
      for (i = 0; i < tbl_used; i++) begin
        if ({2'b0, tbl_len[i]} >= need) begin
          g = '{ST_OK, tbl_start[i] + DataOffset, need[31:0]};
          tbl_start[i] = tbl_start[i] + need[31:0];
          tbl_len[i]   = tbl_len[i] - need[31:0];
          if (tbl_len[i] == 0) drop_hole(i);
          return g;
        end
      end
      return g;
    end
    if (r.size == 0) return g;
    top = {2'b0, r.addr} + r.size;
    if (top > 34'hFFFF_FFFF) begin
      g.st = ST_LEAKED;
      return g;
    end
    for (i = 0; i < tbl_used; i++) begin
      e = {2'b0, tbl_start[i]} + tbl_len[i];
      if (e == {2'b0, r.addr}) begin
        tbl_len[i] = top[31:0] - tbl_start[i];
        if (i + 1 < tbl_used && top == {2'b0, tbl_start[i+1]}) begin
          tbl_len[i] = tbl_start[i+1] + tbl_len[i+1] - tbl_start[i];
          drop_hole(i + 1);
        end
        return g;
      end
      if (tbl_start[i] > r.addr) break;
    end
    if (i < tbl_used && top == {2'b0, tbl_start[i]}) begin
      tbl_start[i] = r.addr;
      tbl_len[i]   = tbl_len[i] + r.size;
      return g;
    end
    if (tbl_used >= NumHoles) begin
      g.st = ST_LEAKED;
      return g;
    end
    for (int unsigned j = tbl_used; j > i; j--) begin
      tbl_start[j] = tbl_start[j-1];
      tbl_len[j]   = tbl_len[j-1];
    end
    tbl_start[i] = r.addr;
    tbl_len[i]   = r.size;
    tbl_used++;
    return g;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("error at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  function automatic void push_req(logic op, logic [31:0] size, logic [31:0] addr);
    req_t r;
    r.op = op; r.size = size; r.addr = addr;
    pending_reqs.push_back(r);
  endfunction

  // driver: one request at a time with a random gap in front of each
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= $urandom_range(0, 19);
    end else if (in_valid && !in_stall) begin
      expected_grants.push_back(predict_grant('{opcode, request_size, region_start}));
      in_valid <= 1'b0;
      in_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    end else if (!in_valid) begin
      if (in_gap != 0) in_gap <= in_gap - 1;
      else if (pending_reqs.size() != 0 &&
               !(drain_hold && expected_grants.size() != 0)) begin
        req_t r;
        r = pending_reqs.pop_front();
        opcode       <= r.op;
        request_size <= r.size;
        region_start <= r.addr;
        in_valid     <= 1'b1;
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  int unsigned out_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result status", {30'd0, status}, 32'd0);
        end else begin
          grant_t g;
          g = expected_grants.pop_front();
          if (status !== g.st) report_mismatch("status", {30'd0, status}, {30'd0, g.st});
          if (data_address !== g.daddr) report_mismatch("data_address", data_address, g.daddr);
          if (granted_bytes !== g.gbytes)
            report_mismatch("granted_bytes", granted_bytes, g.gbytes);
          case (g.st)
            ST_OK:     if (g.gbytes != 0) n_alloc_ok++; else n_release_ok++;
            ST_NOFIT:  n_nofit++;
            default:   n_leaked++;
          endcase
        end
        out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (out_gap != 0) begin
        out_stall <= 1'b1;
        out_gap = out_gap - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake
  int unsigned quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [31:0] a, s, base;
    int unsigned k;
    // directed: pool release, extremes, merges, zero and top cases
    push_req(OP_RELEASE, 32'h0001_0000, 32'h0010_0000);
    push_req(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    push_req(OP_ALLOC, 32'd1, 32'd0);
    push_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    push_req(OP_ALLOC, 32'hFFFF_FFEC, 32'd0);
    push_req(OP_ALLOC, 32'hFFFF_FFE0, 32'd0);
    push_req(OP_RELEASE, 32'd0, 32'h1234_5678);
    push_req(OP_RELEASE, 32'h0000_0010, 32'hFFFF_FFF8);
    push_req(OP_RELEASE, 32'hFFFF_FFFF, 32'd1);
    push_req(OP_RELEASE, 32'h0000_0100, 32'h0020_0000);
    push_req(OP_RELEASE, 32'h0000_0100, 32'h0020_0200);
    push_req(OP_RELEASE, 32'h0000_0100, 32'h0020_0100);
    push_req(OP_RELEASE, 32'h0000_0040, 32'h0020_0300);
    push_req(OP_RELEASE, 32'h0000_0040, 32'h001F_FFC0);
    push_req(OP_RELEASE, 32'h0000_0008, 32'hFFFF_FFF7);
    push_req(OP_RELEASE, 32'h0000_0001, 32'd0);
    push_req(OP_ALLOC, 32'h0000_FFEC, 32'd0);
    push_req(OP_ALLOC, 32'h0000_0300, 32'd0);
    push_req(OP_ALLOC, 32'h0001_0000, 32'd0);
    // fill the table to force leaks, then issue small allocations
    for (k = 0; k < NumHoles + 4; k++)
      push_req(OP_RELEASE, 32'd8, 32'h4000_0000 + k * 32);
    for (k = 0; k < 40; k++) push_req(OP_ALLOC, 32'd0, $urandom);
    wait (pending_reqs.size() == 0 && expected_grants.size() == 0);
    // random: alloc heavy with releases near existing holes, some noise
    base = 32'h0800_0000;
    for (k = 0; k < 1400; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_req(OP_ALLOC, $urandom_range(0, 300), $urandom);
        4: push_req(OP_ALLOC, $urandom, $urandom);
        5, 6: begin
          a = base + 8 * $urandom_range(0, 4000);
          push_req(OP_RELEASE, 8 * $urandom_range(1, 32), a);
        end
        7: begin
          s = 8 * $urandom_range(1, 16);
          a = base + 256 * $urandom_range(0, 500);
          push_req(OP_RELEASE, s, a);
          push_req(OP_RELEASE, s, a + s);
        end
        8: push_req(OP_RELEASE, $urandom, $urandom);
        default: push_req(OP_ALLOC, $urandom_range(0, 2000), $urandom);
      endcase
      if (k == 700) begin
        wait (pending_reqs.size() == 0);
        drain_hold = 1'b1;
        wait (expected_grants.size() == 0);
        drain_hold = 1'b0;
      end
    end
    stim_done = 1'b1;
  end

  // reset and end of run
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && pending_reqs.size() == 0 && !in_valid &&
          expected_grants.size() == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d allocations granted, %0d no fit, %0d leaked, %0d releases",
             n_alloc_ok, n_nofit, n_leaked, n_release_ok);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_ram.sv
sv/first_fit_hole_allocator.sv
tb/sv/tb.sv
